### sv/fpm_pkg.sv
// Shared types and constants for the FIFO page mapper.
// Used by fpm_fifo, fpm_page_table and fifo_page_mapper; no dependencies.
package fpm_pkg;

  localparam int unsigned ADDR_W     = 14;
  localparam int unsigned PAGE_COUNT = 16;
  localparam int unsigned PAGE_BYTES = 1024;
  localparam int unsigned PAGE_W     = $clog2(PAGE_COUNT);
  localparam int unsigned OFFS_W     = $clog2(PAGE_BYTES);

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_ALLOC = 2'd2,
    REQ_FREE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_HIT          = 3'd0,
    ST_FAULT        = 3'd1,
    ST_ALLOCATED    = 3'd2,
    ST_FREED        = 3'd3,
    ST_NO_INVALID   = 3'd4,
    ST_FREE_INVALID = 3'd5
  } status_e;

  typedef struct packed {
    logic pop;
    logic rm;
    logic push;
  } fifo_ctl_t;

  typedef struct packed {
    logic              set_en;
    logic              set_dirty;
    logic [PAGE_W-1:0] set_page;
    logic              clr_en;
    logic [PAGE_W-1:0] clr_page;
  } tbl_upd_t;

endpackage

### sv/fpm_fifo.sv
// Ordered queue with pop at head, removal by value and push at tail, compacted in place.
// Holds the free frame list and the resident page order. Depends on fpm_pkg.
module fpm_fifo #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 4,
  parameter bit          FILL  = 1'b0,
  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fpm_pkg::fifo_ctl_t ctl_i,
  input  logic [WIDTH-1:0]  rm_value_i,
  input  logic [WIDTH-1:0]  push_value_i,
  output logic [WIDTH-1:0]  head_o,
  output logic [CNT_W-1:0]  count_o
);
  import fpm_pkg::*;

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [WIDTH-1:0] data_d [DEPTH];
  logic [CNT_W-1:0] count_q, count_d, cnt_mid;
  logic [IDX_W-1:0] rm_pos, drop_pos;
  logic             rm_hit, drop, push_ok;

  always_comb begin
    rm_hit = 1'b0;
    rm_pos = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (CNT_W'(i) < count_q && data_q[i] == rm_value_i) begin
        rm_hit = 1'b1;
        rm_pos = IDX_W'(i);
      end
    end
    drop     = (ctl_i.pop && count_q != '0) || (ctl_i.rm && rm_hit);
    drop_pos = ctl_i.pop ? '0 : rm_pos;
    cnt_mid  = count_q - CNT_W'(drop);
    push_ok  = ctl_i.push && cnt_mid < CNT_W'(DEPTH);
    count_d  = cnt_mid + CNT_W'(push_ok);
    for (int i = 0; i < DEPTH; i++) begin
      if (drop && IDX_W'(i) >= drop_pos) begin
        data_d[i] = data_q[(i + 1 < DEPTH) ? i + 1 : i];
      end else begin
        data_d[i] = data_q[i];
      end
      if (push_ok && cnt_mid == CNT_W'(i)) begin
        data_d[i] = push_value_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= FILL ? CNT_W'(DEPTH) : '0;
    end else begin
      count_q <= count_d;
    end
  end

  if (FILL) begin : g_fill
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        for (int i = 0; i < DEPTH; i++) data_q[i] <= WIDTH'(i);
      end else begin
        data_q <= data_d;
      end
    end
  end else begin : g_plain
    always_ff @(posedge clk_i) begin
      data_q <= data_d;
    end
  end

  assign head_o  = data_q[0];
  assign count_o = count_q;

endmodule

### sv/fpm_page_table.sv
// Page table: valid and dirty flags, frame per page, lowest invalid page search.
// Depends on fpm_pkg.
module fpm_page_table #(
  parameter int unsigned FRAME_W = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fpm_pkg::tbl_upd_t           upd_i,
  input  logic [FRAME_W-1:0]          set_frame_i,
  input  logic [fpm_pkg::PAGE_W-1:0]  look_page_i,
  output logic [fpm_pkg::PAGE_COUNT-1:0] valid_o,
  output logic                        look_dirty_o,
  output logic [FRAME_W-1:0]          look_frame_o,
  output logic                        alloc_found_o,
  output logic [fpm_pkg::PAGE_W-1:0]  alloc_page_o
);
  import fpm_pkg::*;

  logic [PAGE_COUNT-1:0] valid_q, valid_d, dirty_q, dirty_d;
  logic [FRAME_W-1:0]    frame_q [PAGE_COUNT];

  always_comb begin
    valid_d = valid_q;
    dirty_d = dirty_q;
    if (upd_i.clr_en) begin
      valid_d[upd_i.clr_page] = 1'b0;
      dirty_d[upd_i.clr_page] = 1'b0;
    end
    if (upd_i.set_en) begin
      valid_d[upd_i.set_page] = 1'b1;
      dirty_d[upd_i.set_page] = upd_i.set_dirty;
    end
  end

  always_comb begin
    alloc_found_o = 1'b0;
    alloc_page_o  = '0;
    for (int i = PAGE_COUNT - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        alloc_found_o = 1'b1;
        alloc_page_o  = PAGE_W'(i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      dirty_q <= '0;
    end else begin
      valid_q <= valid_d;
      dirty_q <= dirty_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.set_en) begin
      frame_q[upd_i.set_page] <= set_frame_i;
    end
  end

  assign valid_o      = valid_q;
  assign look_dirty_o = dirty_q[look_page_i];
  assign look_frame_o = frame_q[look_page_i];

endmodule

### sv/fifo_page_mapper.sv
// FIFO page mapper top level: input register, one pass of mapping logic, result register.
// Throughput: one word per cycle unless the output stalls; the page table, free list
// and resident queue update in the cycle that moves a word from the input register
// into the result register.
// Reset: all pages invalid and clean, free list holds every frame in order, no clearing pass.
// Depends on fpm_pkg, fpm_page_table and fpm_fifo.
module fifo_page_mapper #(
  parameter int unsigned FRAME_COUNT = 4,
  localparam int unsigned FRAME_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  req_type_i,
  input  logic [fpm_pkg::ADDR_W-1:0]  address_i,
  input  logic [fpm_pkg::PAGE_W-1:0]  free_target_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic [fpm_pkg::PAGE_W-1:0]  page_o,
  output logic [FRAME_W-1:0]          frame_o,
  output logic                        load_from_disk_o,
  output logic                        write_back_o,
  output logic [fpm_pkg::PAGE_W-1:0]  write_back_page_o,
  output logic                        evicted_o,
  output logic [fpm_pkg::PAGE_W-1:0]  evicted_page_o
);
  import fpm_pkg::*;

  localparam int unsigned CNT_W = $clog2(FRAME_COUNT + 1);

  logic              in_vld_q, out_vld_q, advance;
  req_e              req_q;
  logic [ADDR_W-1:0] addr_q;
  logic [PAGE_W-1:0] tgt_q;

  logic [PAGE_COUNT-1:0] valid;
  logic                  look_dirty, alloc_found;
  logic [FRAME_W-1:0]    look_frame, free_head, new_frame, set_frame;
  logic [PAGE_W-1:0]     alloc_page, addr_page, acc_page, look_page, res_head;
  logic [CNT_W-1:0]      free_cnt, res_cnt;
  logic                  is_rw, hit_rw, need_frame, use_free, do_evict, free_ok, wb;
  tbl_upd_t              tbl_upd;
  fifo_ctl_t             free_ctl, res_ctl;

  status_e           status_d, status_q;
  logic [PAGE_W-1:0] page_d, page_q, wb_page_d, wb_page_q, ev_page_d, ev_page_q;
  logic [FRAME_W-1:0] frame_d, frame_q;
  logic              load_q, wb_q, ev_q;

  assign in_stall_o = in_vld_q && out_vld_q && out_stall_i;
  assign advance    = in_vld_q && !(out_vld_q && out_stall_i);

  always_comb begin
    addr_page  = addr_q[OFFS_W +: PAGE_W];
    is_rw      = (req_q == REQ_READ) || (req_q == REQ_WRITE);
    hit_rw     = is_rw && valid[addr_page];
    acc_page   = is_rw ? addr_page : alloc_page;
    need_frame = (is_rw && !valid[addr_page]) || (req_q == REQ_ALLOC && alloc_found);
    use_free   = free_cnt != '0;
    do_evict   = need_frame && !use_free && res_cnt != '0;
    free_ok    = (req_q == REQ_FREE) && valid[tgt_q];
    look_page  = (req_q == REQ_FREE) ? tgt_q : (do_evict ? res_head : acc_page);
    new_frame  = use_free ? free_head : (do_evict ? look_frame : '0);
    set_frame  = need_frame ? new_frame : look_frame;

    tbl_upd.set_en    = advance && (need_frame || (req_q == REQ_WRITE && hit_rw));
    tbl_upd.set_dirty = req_q == REQ_WRITE;
    tbl_upd.set_page  = acc_page;
    tbl_upd.clr_en    = advance && (do_evict || free_ok);
    tbl_upd.clr_page  = free_ok ? tgt_q : res_head;

    free_ctl.pop  = advance && need_frame && use_free;
    free_ctl.rm   = 1'b0;
    free_ctl.push = advance && free_ok;
    res_ctl.pop   = advance && do_evict;
    res_ctl.rm    = advance && free_ok;
    res_ctl.push  = advance && need_frame;

    wb = (do_evict || free_ok) && look_dirty;
    case (req_q)
      REQ_READ, REQ_WRITE: status_d = hit_rw ? ST_HIT : ST_FAULT;
      REQ_ALLOC:           status_d = alloc_found ? ST_ALLOCATED : ST_NO_INVALID;
      REQ_FREE:            status_d = free_ok ? ST_FREED : ST_FREE_INVALID;
      default:             status_d = ST_HIT;
    endcase
    page_d    = (req_q == REQ_FREE) ? tgt_q : ((is_rw || alloc_found) ? acc_page : '0);
    frame_d   = need_frame ? new_frame : ((hit_rw || free_ok) ? look_frame : '0);
    wb_page_d = wb ? tbl_upd.clr_page : '0;
    ev_page_d = do_evict ? res_head : '0;
  end

  fpm_page_table #(
    .FRAME_W(FRAME_W)
  ) u_table (
    .clk_i,
    .rst_ni,
    .upd_i        (tbl_upd),
    .set_frame_i  (set_frame),
    .look_page_i  (look_page),
    .valid_o      (valid),
    .look_dirty_o (look_dirty),
    .look_frame_o (look_frame),
    .alloc_found_o(alloc_found),
    .alloc_page_o (alloc_page)
  );

  fpm_fifo #(
    .WIDTH(FRAME_W),
    .DEPTH(FRAME_COUNT),
    .FILL (1'b1)
  ) u_free_list (
    .clk_i,
    .rst_ni,
    .ctl_i       (free_ctl),
    .rm_value_i  (look_frame),
    .push_value_i(look_frame),
    .head_o      (free_head),
    .count_o     (free_cnt)
  );

  fpm_fifo #(
    .WIDTH(PAGE_W),
    .DEPTH(FRAME_COUNT),
    .FILL (1'b0)
  ) u_resident (
    .clk_i,
    .rst_ni,
    .ctl_i       (res_ctl),
    .rm_value_i  (tgt_q),
    .push_value_i(acc_page),
    .head_o      (res_head),
    .count_o     (res_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_vld_q <= in_valid_i;
      end
      if (!(out_vld_q && out_stall_i)) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q  <= req_e'(req_type_i);
      addr_q <= address_i;
      tgt_q  <= free_target_i;
    end
    if (advance) begin
      status_q  <= status_d;
      page_q    <= page_d;
      frame_q   <= frame_d;
      load_q    <= need_frame;
      wb_q      <= wb;
      wb_page_q <= wb_page_d;
      ev_q      <= do_evict;
      ev_page_q <= ev_page_d;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign status_o          = status_q;
  assign page_o            = page_q;
  assign frame_o           = frame_q;
  assign load_from_disk_o  = load_q;
  assign write_back_o      = wb_q;
  assign write_back_page_o = wb_page_q;
  assign evicted_o         = ev_q;
  assign evicted_page_o    = ev_page_q;

`ifndef NO_ASSERTIONS
  a_frame_balance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, free_cnt} + {1'b0, res_cnt}) == (CNT_W + 1)'(FRAME_COUNT))
    else $error("free and resident counts do not cover every frame");

  a_evict_on_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && ev_q |-> (status_q == ST_FAULT || status_q == ST_ALLOCATED))
    else $error("eviction reported without a fault or allocation");

  a_wb_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && wb_q |-> (status_q == ST_FREED || (ev_q && wb_page_q == ev_page_q)))
    else $error("write-back page does not match the released page");

  a_evict_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_ctl.pop |-> free_cnt == '0)
    else $error("eviction while a free frame remains");
`endif

endmodule

### dv/tb_fifo_page_mapper.sv
// Self-checking testbench for fifo_page_mapper: directed and random requests with
// bursty input, patterned output stalls and one long output hold-off.
// Depends on fpm_pkg and the fifo_page_mapper RTL.
`timescale 1ns / 1ps

module tb_fifo_page_mapper;
  import fpm_pkg::*;

  localparam int FRAMES     = 4;
  localparam int FRM_W      = 2;
  localparam int RAND_ITEMS = 1400;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_LEN   = 300;

  typedef struct {
    req_e             req;
    logic [ADDR_W-1:0] addr;
    logic [PAGE_W-1:0] tgt;
  } page_req_t;

  typedef struct packed {
    status_e           status;
    logic [PAGE_W-1:0] page;
    logic [FRM_W-1:0]  frame;
    logic              load;
    logic              wb;
    logic [PAGE_W-1:0] wb_page;
    logic              ev;
    logic [PAGE_W-1:0] ev_page;
  } map_res_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [1:0]          req_type_i = '0;
  logic [ADDR_W-1:0]   address_i = '0;
  logic [PAGE_W-1:0]   free_target_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [2:0]          status_o;
  logic [PAGE_W-1:0]   page_o;
  logic [FRM_W-1:0]    frame_o;
  logic                load_from_disk_o;
  logic                write_back_o;
  logic [PAGE_W-1:0]   write_back_page_o;
  logic                evicted_o;
  logic [PAGE_W-1:0]   evicted_page_o;

  fifo_page_mapper #(.FRAME_COUNT(FRAMES)) DUT (.*);

  always #4 clk_i = ~clk_i;

  page_req_t pending_reqs[$];
  map_res_t  expected_maps[$];

  logic             pg_valid[PAGE_COUNT];
  logic             pg_dirty[PAGE_COUNT];
  logic [FRM_W-1:0] pg_frame[PAGE_COUNT];
  logic [FRM_W-1:0] free_list[FRAMES];
  int               free_cnt;
  logic [PAGE_W-1:0] resident_q[FRAMES];
  int               resident_cnt;

  int errors = 0;
  int accepted_reqs = 0;
  int checked_words = 0;
  int n_status[6];
  int n_evict = 0;
  int n_wb = 0;

  function automatic logic [FRM_W-1:0] claim_frame(input logic [PAGE_W-1:0] pg,
                                                   inout map_res_t r);
    logic [FRM_W-1:0]  fr;
    logic [PAGE_W-1:0] victim;
    fr = '0;
    if (free_cnt > 0) begin
      fr = free_list[0];
      for (int i = 0; i + 1 < FRAMES; i++) free_list[i] = free_list[i+1];
      free_cnt--;
    end else if (resident_cnt > 0) begin
      victim = resident_q[0];
      for (int i = 0; i + 1 < FRAMES; i++) resident_q[i] = resident_q[i+1];
      resident_cnt--;
      fr = pg_frame[victim];
      if (pg_dirty[victim]) begin
        r.wb = 1'b1;
        r.wb_page = victim;
      end
      r.ev = 1'b1;
      r.ev_page = victim;
      pg_valid[victim] = 1'b0;
      pg_dirty[victim] = 1'b0;
    end
    pg_valid[pg] = 1'b1;
    pg_frame[pg] = fr;
    pg_dirty[pg] = 1'b0;
    if (resident_cnt < FRAMES) begin
      resident_q[resident_cnt] = pg;
      resident_cnt++;
    end
    r.load = 1'b1;
    return fr;
  endfunction

  function automatic map_res_t map_request(input page_req_t rq);
    map_res_t          r;
    logic [PAGE_W-1:0] pg;
    logic [FRM_W-1:0]  fr;
    bit                found;
    int                j;
    r = '0;
    r.status = ST_HIT;
    if (rq.req == REQ_READ || rq.req == REQ_WRITE) begin
      pg = PAGE_W'((rq.addr / PAGE_BYTES) % PAGE_COUNT);
      r.page = pg;
      if (pg_valid[pg]) begin
        r.frame = pg_frame[pg];
      end else begin
        r.status = ST_FAULT;
        r.frame = claim_frame(pg, r);
      end
      if (rq.req == REQ_WRITE) pg_dirty[pg] = 1'b1;
    end else if (rq.req == REQ_ALLOC) begin
      found = 1'b0;
      pg = '0;
      for (int i = 0; i < PAGE_COUNT; i++) begin
        if (!found && !pg_valid[i]) begin
          pg = PAGE_W'(i);
          found = 1'b1;
        end
      end
      if (found) begin
        r.status = ST_ALLOCATED;
        r.page = pg;
        r.frame = claim_frame(pg, r);
      end else begin
        r.status = ST_NO_INVALID;
      end
    end else begin
      r.page = rq.tgt;
      if (pg_valid[rq.tgt]) begin
        fr = pg_frame[rq.tgt];
        r.status = ST_FREED;
        r.frame = fr;
        if (pg_dirty[rq.tgt]) begin
          r.wb = 1'b1;
          r.wb_page = rq.tgt;
        end
        pg_valid[rq.tgt] = 1'b0;
        pg_dirty[rq.tgt] = 1'b0;
        if (free_cnt < FRAMES) begin
          free_list[free_cnt] = fr;
          free_cnt++;
        end
        j = 0;
        for (int i = 0; i < resident_cnt; i++) begin
          if (resident_q[i] != rq.tgt) begin
            resident_q[j] = resident_q[i];
            j++;
          end
        end
        resident_cnt = j;
      end else begin
        r.status = ST_FREE_INVALID;
      end
    end
    return r;
  endfunction

  function automatic void add_req(input req_e req, input int addr, input int tgt);
    page_req_t rq;
    rq.req = req;
    rq.addr = ADDR_W'(addr);
    rq.tgt = PAGE_W'(tgt);
    pending_reqs.push_back(rq);
  endfunction

  function automatic void check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      burst_left = $urandom_range(1, 20);
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_maps.push_back(map_request(pending_reqs.pop_front()));
        accepted_reqs++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_valid_i <= 1'b1;
          req_type_i <= pending_reqs[0].req;
          address_i <= pending_reqs[0].addr;
          free_target_i <= pending_reqs[0].tgt;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 20);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall on a reloaded bit pattern, plus one long hold-off.
  logic [15:0] stall_pat = '0;
  int pat_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int rx_words = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) rx_words++;
      if (!hold_done && rx_words >= 300) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (pat_cnt == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pat = '0;
          1: stall_pat = 16'($urandom);
          2: stall_pat = 16'($urandom & $urandom);
          default: stall_pat = 16'($urandom | $urandom);
        endcase
        pat_cnt = 16;
      end
      out_stall_i <= (hold_left > 0) || stall_pat[0];
      stall_pat = stall_pat >> 1;
      pat_cnt--;
      if (hold_left > 0) hold_left--;
    end
  end

  always @(posedge clk_i) begin
    map_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_maps.size() == 0) begin
        $display("%0t ns: unexpected word, expected none actual status %0d page %0d",
                 $time, status_o, page_o);
        errors++;
      end else begin
        e = expected_maps.pop_front();
        check_field("status", e.status, status_o);
        check_field("page", e.page, page_o);
        check_field("frame", e.frame, frame_o);
        check_field("load_from_disk", e.load, load_from_disk_o);
        check_field("write_back", e.wb, write_back_o);
        check_field("write_back_page", e.wb_page, write_back_page_o);
        check_field("evicted", e.ev, evicted_o);
        check_field("evicted_page", e.ev_page, evicted_page_o);
        checked_words++;
        if (e.status <= ST_FREE_INVALID) n_status[e.status]++;
        if (e.ev) n_evict++;
        if (e.wb) n_wb++;
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: timeout with %0d words outstanding", $time, expected_maps.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int hot;
    int op;
    for (int i = 0; i < PAGE_COUNT; i++) begin
      pg_valid[i] = 1'b0;
      pg_dirty[i] = 1'b0;
      pg_frame[i] = '0;
    end
    for (int i = 0; i < FRAMES; i++) begin
      free_list[i] = FRM_W'(i);
      resident_q[i] = '0;
    end
    free_cnt = FRAMES;
    resident_cnt = 0;
    foreach (n_status[i]) n_status[i] = 0;

    add_req(REQ_READ, 0, 0);
    add_req(REQ_READ, 16383, 15);
    add_req(REQ_WRITE, 1023, 0);
    add_req(REQ_ALLOC, 0, 0);
    add_req(REQ_WRITE, 15 * 1024 + 5, 0);
    add_req(REQ_FREE, 0, 7);
    add_req(REQ_READ, 2 * 1024, 0);
    add_req(REQ_READ, 3 * 1024 + 7, 0);
    add_req(REQ_WRITE, 4 * 1024, 0);
    add_req(REQ_FREE, 0, 1);
    add_req(REQ_FREE, 0, 4);
    add_req(REQ_ALLOC, 0, 0);
    add_req(REQ_WRITE, 14'h2AAA, 0);
    add_req(REQ_WRITE, 14'h1555, 0);
    add_req(REQ_ALLOC, 0, 0);
    add_req(REQ_ALLOC, 0, 0);
    add_req(REQ_FREE, 0, 15);
    add_req(REQ_FREE, 0, 0);
    add_req(REQ_READ, 14'h3C00, 0);
    add_req(REQ_FREE, 0, 15);
    add_req(REQ_READ, 14'h3FFF, 0);

    // Keep most traffic on a few hot pages so hits, evictions and frees all occur.
    for (int n = 0; n < RAND_ITEMS; n++) begin
      hot = $urandom_range(0, 5);
      op = $urandom_range(0, 99);
      if (op < 40) begin
        add_req(REQ_READ, ($urandom_range(0, 9) < 6) ? hot * 1024 + $urandom_range(0, 1023)
                                                     : $urandom_range(0, 16383),
                $urandom_range(0, 15));
      end else if (op < 70) begin
        add_req(REQ_WRITE, ($urandom_range(0, 9) < 6) ? hot * 1024 + $urandom_range(0, 1023)
                                                      : $urandom_range(0, 16383),
                $urandom_range(0, 15));
      end else if (op < 85) begin
        add_req(REQ_ALLOC, $urandom_range(0, 16383), $urandom_range(0, 15));
      end else begin
        add_req(REQ_FREE, $urandom_range(0, 16383),
                ($urandom_range(0, 9) < 6) ? hot : $urandom_range(0, 15));
      end
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() > 0 || in_valid_i || expected_maps.size() > 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Checked %0d of %0d requests: %0d hits, %0d faults, %0d allocations,",
             checked_words, accepted_reqs, n_status[ST_HIT], n_status[ST_FAULT],
             n_status[ST_ALLOCATED]);
    $display("  %0d frees, %0d frees of invalid pages, %0d evictions, %0d write-backs.",
             n_status[ST_FREED], n_status[ST_FREE_INVALID], n_evict, n_wb);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
